// ===== rtl/mp4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_pkg
// Shared types and constants of the 4x4 fixed-point matrix product block.
// ----------------------------------------------------------------------------
package mp4_pkg;

    // default matrix order
    localparam int DIM_DEF = 4;
    // columns carried by one transaction
    localparam int NCOL    = 4;
    // element width, signed Q16.16
    localparam int DATA_W  = 32;
    // truncated product width: 64-bit product without its low 16 bits
    localparam int TERM_W  = 48;
    localparam int FRAC_W  = 16;

    // one input transaction: one row of each operand
    typedef struct packed {
        logic signed [DATA_W-1:0] left_col0;
        logic signed [DATA_W-1:0] left_col1;
        logic signed [DATA_W-1:0] left_col2;
        logic signed [DATA_W-1:0] left_col3;
        logic signed [DATA_W-1:0] right_col0;
        logic signed [DATA_W-1:0] right_col1;
        logic signed [DATA_W-1:0] right_col2;
        logic signed [DATA_W-1:0] right_col3;
    } t_in_item;

    // one output transaction: one product row
    typedef struct packed {
        logic [1:0]               row_index;
        logic signed [DATA_W-1:0] prod_col0;
        logic signed [DATA_W-1:0] prod_col1;
        logic signed [DATA_W-1:0] prod_col2;
        logic signed [DATA_W-1:0] prod_col3;
        logic                     last_row;
    } t_out_item;

    // step tag travelling alongside the multiply-accumulate pipeline
    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic       last_row;
        logic [1:0] row_index;
    } t_mac_ctl;

endpackage

// ===== rtl/mp4_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_store
// Matrix row memory: one row per entry, one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mp4_store #(
    parameter int DIM = mp4_pkg::DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DIM)-1:0]           i_wr_addr,
    input  logic [DIM*mp4_pkg::DATA_W-1:0]   i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DIM)-1:0]           i_rd_addr,
    output logic [DIM*mp4_pkg::DATA_W-1:0]   o_rd_data
);
    import mp4_pkg::*;

    logic [DIM*DATA_W-1:0] r_mem [DIM];
    logic [DIM*DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/mp4_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_mac
// Row-by-scalar multiply-accumulate lanes: one scalar of the left matrix
// times one row of the right matrix per step, truncated and accumulated.
// ----------------------------------------------------------------------------
module mp4_mac #(
    parameter int DIM = mp4_pkg::DIM_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_adv,
    input  mp4_pkg::t_mac_ctl                            i_ctl,
    input  logic signed [mp4_pkg::DATA_W-1:0]            i_scalar,
    input  logic [DIM*mp4_pkg::DATA_W-1:0]               i_rrow,
    output mp4_pkg::t_mac_ctl                            o_ctl,
    output logic [mp4_pkg::NCOL-1:0][mp4_pkg::DATA_W-1:0] o_sat
);
    import mp4_pkg::*;

    localparam int ACC_W = TERM_W + $clog2(DIM);

    t_mac_ctl                  r_ctl2;
    t_mac_ctl                  r_ctl3;
    logic signed [TERM_W-1:0]  r_term [NCOL];
    logic signed [ACC_W-1:0]   r_acc  [NCOL];

    // step tags follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_adv) begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
        end
    end

    for (genvar j = 0; j < NCOL; j++) begin : g_lane
        logic signed [DATA_W-1:0]   w_rv;
        logic signed [2*DATA_W-1:0] w_prod;
        logic signed [ACC_W-1:0]    n_acc;
        logic [ACC_W-DATA_W:0]      w_top;

        // lanes past the matrix order multiply by zero
        if (j < DIM) begin : g_used
            assign w_rv = i_rrow[j*DATA_W +: DATA_W];
        end else begin : g_unused
            assign w_rv = '0;
        end

        // product, low fraction bits dropped (floor)
        assign w_prod = i_scalar * w_rv;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_term[j] <= w_prod[2*DATA_W-1:FRAC_W];
            end
        end

        // accumulate, restarting on the first step of a row
        always_comb begin
            if (r_ctl2.first) begin
                n_acc = ACC_W'(r_term[j]);
            end else begin
                n_acc = r_acc[j] + ACC_W'(r_term[j]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv && r_ctl2.vld) begin
                r_acc[j] <= n_acc;
            end
        end

        // saturate to the signed 32-bit range
        assign w_top = r_acc[j][ACC_W-1:DATA_W-1];
        always_comb begin
            if ((&w_top) || !(|w_top)) begin
                o_sat[j] = r_acc[j][DATA_W-1:0];
            end else if (w_top[ACC_W-DATA_W]) begin
                o_sat[j] = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                o_sat[j] = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    assign o_ctl = r_ctl3;

endmodule

// ===== rtl/matrix_product_4x4_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_product_4x4_top
// Product of two square signed Q16.16 matrices, loaded row by row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in): each transaction carries
//   one row of the left and one row of the right matrix, rows in order.
//   After DIM rows the block computes P = L * R and sends DIM output
//   transactions (o_out_valid / i_out_stall / o_out), rows 0 to DIM-1,
//   the final one marked with last_row. Products drop their low 16 bits,
//   row sums saturate to 32 bits.
//   A burst is DIM input transactions followed by DIM*DIM
//   multiply-accumulate steps; each finished row passes the read,
//   term, accumulator and output registers. The step rate is set by the
//   single read port of each row memory, one left scalar and one right
//   row per cycle while the step pipeline is not frozen.
//   The input is stalled while the steps are issued; loading of the next
//   pair starts while the last rows still drain.
//   Reset clears the sequencer and output valid; the block then accepts
//   input. The memories are not cleared. When the receiver stalls, the
//   output holds and the step pipeline freezes once a finished row waits.
// ----------------------------------------------------------------------------
module matrix_product_4x4_top #(
    parameter int DIM = mp4_pkg::DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mp4_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mp4_pkg::t_out_item o_out
);
    import mp4_pkg::*;

    localparam int AW = $clog2(DIM);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_load_row, n_load_row;
    logic [AW-1:0]                r_i, n_i;
    logic [AW-1:0]                r_k, n_k;
    logic [AW-1:0]                r_k1;
    t_mac_ctl                     r_ctl1;
    t_mac_ctl                     w_ctl0;
    t_mac_ctl                     w_ctl3;
    logic                         w_accept;
    logic                         w_done;
    logic                         w_adv;
    logic                         w_out_load;
    logic [DIM*DATA_W-1:0]        w_left_wr;
    logic [DIM*DATA_W-1:0]        w_right_wr;
    logic [DIM*DATA_W-1:0]        w_left_rd;
    logic [DIM*DATA_W-1:0]        w_right_rd;
    logic signed [DATA_W-1:0]     w_scalar;
    logic [NCOL-1:0][DATA_W-1:0]  w_sat;
    logic [DATA_W-1:0]            w_left_in  [NCOL];
    logic [DATA_W-1:0]            w_right_in [NCOL];
    logic                         r_out_vld;
    t_out_item                    r_out;

    // input handshake
    assign o_in_stall = (r_state != ST_LOAD);
    assign w_accept   = i_in_valid && !o_in_stall;

    // pipeline freezes only when a finished row cannot leave
    assign w_done     = w_ctl3.vld && w_ctl3.last;
    assign w_adv      = !(w_done && r_out_vld && i_out_stall);
    assign w_out_load = w_done && w_adv;

    // pack one incoming row, columns past the transaction load as zero
    assign w_left_in[0]  = i_in.left_col0;
    assign w_left_in[1]  = i_in.left_col1;
    assign w_left_in[2]  = i_in.left_col2;
    assign w_left_in[3]  = i_in.left_col3;
    assign w_right_in[0] = i_in.right_col0;
    assign w_right_in[1] = i_in.right_col1;
    assign w_right_in[2] = i_in.right_col2;
    assign w_right_in[3] = i_in.right_col3;

    for (genvar c = 0; c < DIM; c++) begin : g_wr
        if (c < NCOL) begin : g_col
            assign w_left_wr[c*DATA_W +: DATA_W]  = w_left_in[c];
            assign w_right_wr[c*DATA_W +: DATA_W] = w_right_in[c];
        end else begin : g_pad
            assign w_left_wr[c*DATA_W +: DATA_W]  = '0;
            assign w_right_wr[c*DATA_W +: DATA_W] = '0;
        end
    end

    // sequencer: load rows, then issue one step (row i, term k) per cycle while not frozen
    always_comb begin
        n_state    = r_state;
        n_load_row = r_load_row;
        n_i        = r_i;
        n_k        = r_k;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (r_load_row == AW'(DIM - 1)) begin
                        n_load_row = '0;
                        n_i        = '0;
                        n_k        = '0;
                        n_state    = ST_RUN;
                    end else begin
                        n_load_row = r_load_row + 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    if (r_k == AW'(DIM - 1)) begin
                        n_k = '0;
                        if (r_i == AW'(DIM - 1)) begin
                            n_state = ST_LOAD;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_row <= '0;
            r_i        <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_row <= n_load_row;
            r_i        <= n_i;
            r_k        <= n_k;
        end
    end

    // step tag for the issued read
    always_comb begin
        w_ctl0           = '0;
        w_ctl0.vld       = (r_state == ST_RUN);
        w_ctl0.first     = (r_k == '0);
        w_ctl0.last      = (r_k == AW'(DIM - 1));
        w_ctl0.last_row  = (r_i == AW'(DIM - 1));
        w_ctl0.row_index = 2'(r_i);
    end

    // row memories: left read at row i, right read at row k
    mp4_store #(.DIM(DIM)) u_left (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_load_row),
        .i_wr_data (w_left_wr),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_i),
        .o_rd_data (w_left_rd)
    );

    mp4_store #(.DIM(DIM)) u_right (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_load_row),
        .i_wr_data (w_right_wr),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_k),
        .o_rd_data (w_right_rd)
    );

    // tag and term index aligned with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (w_adv) begin
            r_ctl1 <= w_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k1 <= r_k;
        end
    end

    // left scalar L[i][k]
    assign w_scalar = w_left_rd[r_k1*DATA_W +: DATA_W];

    mp4_mac #(.DIM(DIM)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_ctl    (r_ctl1),
        .i_scalar (w_scalar),
        .i_rrow   (w_right_rd),
        .o_ctl    (w_ctl3),
        .o_sat    (w_sat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.row_index <= w_ctl3.row_index;
            r_out.prod_col0 <= w_sat[0];
            r_out.prod_col1 <= w_sat[1];
            r_out.prod_col2 <= w_sat[2];
            r_out.prod_col3 <= w_sat[3];
            r_out.last_row  <= w_ctl3.last_row;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// ===== rtl/mp4_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_chk
// Port-level checks of the matrix product block, bound to the top level.
// ----------------------------------------------------------------------------
module mp4_chk #(
    parameter int DIM = mp4_pkg::DIM_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mp4_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mp4_pkg::t_out_item o_out
);
    import mp4_pkg::*;

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output changed while stalled");

    // reset leaves no output pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset leaves the block ready to load
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // the marked row is the final row of the product
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last_row |-> o_out.row_index == 2'(DIM - 1))
        else $error("last row carries wrong index");

    // a stalled input transaction holds until accepted
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in))
        else $error("input changed while stalled");

endmodule

bind matrix_product_4x4_top mp4_chk #(.DIM(DIM)) u_mp4_chk (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_product_4x4_top. Matrix pairs are loaded row
// by row through the input channel. A scoreboard keeps its own copy of both
// operands and computes the expected product rows: each term is truncated to
// Q16.16, and each row sum saturates. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    import mp4_pkg::*;

    localparam int N_DIM        = DIM_DEF;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_BURSTS  = 50;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [DATA_W-1:0] t_elem;
    typedef t_elem t_mat [N_DIM][N_DIM];

    localparam t_elem ELEM_MAX = 32'sh7FFF_FFFF;
    localparam t_elem ELEM_MIN = 32'sh8000_0000;
    localparam t_elem ONE_Q    = 32'sh0001_0000;
    localparam t_elem HALF_Q   = 32'sh0000_8000;

    // operand copy, product prediction and row check
    class matmul_board;
        t_elem     left_rows[N_DIM][N_DIM];
        t_elem     right_rows[N_DIM][N_DIM];
        int        rows_held;
        t_out_item pending_rows[$];
        int        n_errors;

        function new();
            rows_held = 0;
            n_errors  = 0;
        endfunction

        // store one accepted transaction, predict the product once complete
        function void load_row(t_in_item item);
            t_out_item row;
            t_elem     prod[NCOL];
            longint    acc;
            left_rows[rows_held][0]  = item.left_col0;
            left_rows[rows_held][1]  = item.left_col1;
            left_rows[rows_held][2]  = item.left_col2;
            left_rows[rows_held][3]  = item.left_col3;
            right_rows[rows_held][0] = item.right_col0;
            right_rows[rows_held][1] = item.right_col1;
            right_rows[rows_held][2] = item.right_col2;
            right_rows[rows_held][3] = item.right_col3;
            rows_held++;
            if (rows_held < N_DIM)
                return;
            rows_held = 0;
            for (int i = 0; i < N_DIM; i++) begin
                for (int j = 0; j < NCOL; j++) begin
                    acc = 0;
                    // each term floors to Q16.16 before the exact sum
                    for (int k = 0; k < N_DIM; k++)
                        acc += (longint'(left_rows[i][k]) * longint'(right_rows[k][j]))
                               >>> FRAC_W;
                    if (acc > longint'(ELEM_MAX))
                        prod[j] = ELEM_MAX;
                    else if (acc < longint'(ELEM_MIN))
                        prod[j] = ELEM_MIN;
                    else
                        prod[j] = t_elem'(acc);
                end
                row.row_index = 2'(i);
                row.prod_col0 = prod[0];
                row.prod_col1 = prod[1];
                row.prod_col2 = prod[2];
                row.prod_col3 = prod[3];
                row.last_row  = (i == N_DIM - 1);
                pending_rows.push_back(row);
            end
        endfunction

        function void note_field(string tag, longint want, longint got);
            if (want != got) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb: mismatch on %s: expected %0d, got %0d", tag, want, got);
            end
        endfunction

        // compare one output transaction with the oldest predicted row
        function void check_row(t_out_item got);
            t_out_item want;
            if (pending_rows.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb: unexpected product row %0d", got.row_index);
                return;
            end
            want = pending_rows.pop_front();
            note_field("row_index", want.row_index, got.row_index);
            note_field("prod_col0", want.prod_col0, got.prod_col0);
            note_field("prod_col1", want.prod_col1, got.prod_col1);
            note_field("prod_col2", want.prod_col2, got.prod_col2);
            note_field("prod_col3", want.prod_col3, got.prod_col3);
            note_field("last_row", want.last_row, got.last_row);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    matmul_board board;
    int          in_max_gap    = 12;
    int          out_max_stall = 12;
    int          cycle_count   = 0;

    matrix_product_4x4_top #(
        .DIM         (N_DIM)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // transaction monitors on both channels
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            board.load_row(in_data);
        if (rst_n && out_valid && !out_stall)
            board.check_row(out_data);
    end

    // receiver: random stall before each output transaction
    initial begin
        int wait_n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            wait_n = $urandom_range(0, out_max_stall);
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // one input transaction after a random gap, held until accepted
    task automatic send_row(input t_in_item item);
        int gap;
        gap = $urandom_range(0, in_max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // sender holds off until every predicted row has been seen
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_rows.size() != 0)
            @(posedge clk);
    endtask

    // load one operand pair, optionally pausing after a given row
    task automatic send_pair(input t_mat lm, input t_mat rm, input int pause_row);
        t_in_item item;
        for (int r = 0; r < N_DIM; r++) begin
            item.left_col0  = lm[r][0];
            item.left_col1  = lm[r][1];
            item.left_col2  = lm[r][2];
            item.left_col3  = lm[r][3];
            item.right_col0 = rm[r][0];
            item.right_col1 = rm[r][1];
            item.right_col2 = rm[r][2];
            item.right_col3 = rm[r][3];
            send_row(item);
            if (r == pause_row)
                hold_until_drained();
        end
    endtask

    // full-range words, small Q16.16 values and corner values
    function automatic t_elem rand_elem();
        case ($urandom_range(0, 5))
            0, 1:    return t_elem'($urandom);
            2, 3, 4: return t_elem'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: begin
                case ($urandom_range(0, 4))
                    0:       return ELEM_MAX;
                    1:       return ELEM_MIN;
                    2:       return '0;
                    3:       return ONE_Q;
                    default: return -ONE_Q;
                endcase
            end
        endcase
    endfunction

    initial begin
        t_mat lm;
        t_mat rm;
        board    = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity on the left routes the right rows through unchanged
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++) begin
                lm[r][c] = (r == c) ? ONE_Q : '0;
                rm[r][c] = t_elem'($urandom);
            end
        send_pair(lm, rm, -1);

        // positive saturation, max times max
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++) begin
                lm[r][c] = ELEM_MAX;
                rm[r][c] = ELEM_MAX;
            end
        send_pair(lm, rm, -1);

        // negative saturation, min times max
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++)
                lm[r][c] = ELEM_MIN;
        send_pair(lm, rm, -1);

        // min times min saturates positive
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++)
                rm[r][c] = ELEM_MIN;
        send_pair(lm, rm, N_DIM - 1);

        // tiny negative products floor to -1 each
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++) begin
                lm[r][c] = -1;
                rm[r][c] = (c == 3) ? t_elem'(0) : t_elem'(1);
            end
        send_pair(lm, rm, -1);

        // alternating extremes against halves, terms cancel without saturating
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++) begin
                lm[r][c] = ((r + c) % 2 != 0) ? ELEM_MAX : ELEM_MIN;
                rm[r][c] = (r == c) ? HALF_Q : -HALF_Q;
            end
        send_pair(lm, rm, -1);

        // random pairs under changing idle patterns
        for (int b = 0; b < RAND_BURSTS; b++) begin
            case (b % 6)
                3: begin
                    in_max_gap    = 0;
                    out_max_stall = 0;
                end
                4: begin
                    in_max_gap    = 0;
                    out_max_stall = 12;
                end
                5: begin
                    in_max_gap    = 12;
                    out_max_stall = 0;
                end
                default: begin
                    in_max_gap    = 12;
                    out_max_stall = 12;
                end
            endcase
            for (int r = 0; r < N_DIM; r++)
                for (int c = 0; c < N_DIM; c++) begin
                    lm[r][c] = rand_elem();
                    rm[r][c] = rand_elem();
                end
            send_pair(lm, rm, (b == 10) ? 1 : ((b == 25) ? N_DIM - 1 : -1));
        end

        // drain, then settle
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.n_errors == 0 && board.pending_rows.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mp4_pkg.sv
rtl/mp4_store.sv
rtl/mp4_mac.sv
rtl/matrix_product_4x4_top.sv
rtl/mp4_chk.sv
sim/tb.sv
